[rtl/htlb_pkg.sv]
package htlb_pkg;

    // default strip length
    localparam int NUM_LEDS_DEF = 32;

    // field widths
    localparam int ACT_W       = 2;
    localparam int HUE_W       = 16;
    localparam int VAL_W       = 16;
    localparam int PIX_IDX_W   = 5;
    localparam int CH_W        = 8;

    // action codes
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DECAY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load_write;
        logic load_decay;
        logic load_clear;
        logic rd_issue;
        logic mul_en;
        logic wb_en;
        logic conv_en;
        logic out_load;
        logic out_clear;
        logic out_refresh;
        logic out_last;
        logic cnt_inc;
    } htlb_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic cnt_last;
        logic out_free;
    } htlb_stat_t;

endpackage

[rtl/htlb_ram.sv]
module htlb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/htlb_ctrl.sv]
module htlb_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [htlb_pkg::ACT_W-1:0]   s_action,
    input  htlb_pkg::htlb_stat_t         stat,
    output htlb_pkg::htlb_cmd_t          cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_MUL,
        ST_WB,
        ST_CONV,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MODE_WRITE,
        MODE_DECAY,
        MODE_CLEAR
    } mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_action)
                        htlb_pkg::ACT_WRITE: begin
                            cmd.load_write = 1'b1;
                            mode_next      = MODE_WRITE;
                            state_next     = ST_CONV;
                        end
                        htlb_pkg::ACT_DECAY: begin
                            cmd.load_decay = 1'b1;
                            mode_next      = MODE_DECAY;
                            state_next     = ST_RD;
                        end
                        htlb_pkg::ACT_CLEAR: begin
                            cmd.load_clear = 1'b1;
                            mode_next      = MODE_CLEAR;
                            state_next     = ST_OUT;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_WB;
            end
            ST_WB: begin
                cmd.wb_en  = 1'b1;
                state_next = ST_CONV;
            end
            ST_CONV: begin
                cmd.conv_en = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                cmd.out_clear   = (mode_reg == MODE_CLEAR);
                cmd.out_refresh = (mode_reg == MODE_WRITE);
                cmd.out_last    = (mode_reg != MODE_DECAY) || stat.cnt_last;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if ((mode_reg == MODE_DECAY) && !stat.cnt_last) begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = ST_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and mode registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_WRITE;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

[rtl/htlb_dp.sv]
module htlb_dp #(
    parameter int NUM_LEDS = htlb_pkg::NUM_LEDS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  htlb_pkg::htlb_cmd_t              cmd,
    output htlb_pkg::htlb_stat_t             stat,
    input  logic [htlb_pkg::VAL_W-1:0]       s_brightness,
    input  logic [htlb_pkg::HUE_W-1:0]       s_hue,
    input  logic [htlb_pkg::VAL_W-1:0]       s_fade,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [htlb_pkg::PIX_IDX_W-1:0]   m_pixel_index,
    output logic [htlb_pkg::CH_W-1:0]        m_red,
    output logic [htlb_pkg::CH_W-1:0]        m_green,
    output logic [htlb_pkg::CH_W-1:0]        m_blue,
    output logic                             m_refresh,
    output logic                             m_clear_all,
    output logic                             m_last
);

    localparam int IDX_W   = $clog2(NUM_LEDS);
    localparam int HUE_W   = htlb_pkg::HUE_W;
    localparam int VAL_W   = htlb_pkg::VAL_W;
    localparam int CH_W    = htlb_pkg::CH_W;
    localparam int PIX_W   = htlb_pkg::PIX_IDX_W;
    localparam int ENT_W   = HUE_W + VAL_W;
    localparam int T_W     = HUE_W + 1;
    localparam int XP_W    = VAL_W + T_W;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(NUM_LEDS - 1);

    // hue sectors
    localparam logic [2:0] SEC_RED_UP    = 3'd0;
    localparam logic [2:0] SEC_GRN_DOWN  = 3'd1;
    localparam logic [2:0] SEC_GRN_UP    = 3'd2;
    localparam logic [2:0] SEC_BLU_DOWN  = 3'd3;
    localparam logic [2:0] SEC_BLU_UP    = 3'd4;

    logic [IDX_W-1:0]     wr_idx_reg;
    logic [IDX_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     pix_idx_reg;
    logic [VAL_W-1:0]     fade_reg;
    logic [HUE_W-1:0]     hue_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [2*VAL_W-1:0]   prod_reg;
    logic [NUM_LEDS-1:0]  valid_reg;
    logic                 rd_valid_reg;
    logic [2:0]           sector_reg;
    logic [XP_W-1:0]      xprod_reg;
    logic [CH_W-1:0]      full_reg;

    logic                 m_valid_reg;
    logic [PIX_W-1:0]     m_idx_reg;
    logic [CH_W-1:0]      m_red_reg;
    logic [CH_W-1:0]      m_green_reg;
    logic [CH_W-1:0]      m_blue_reg;
    logic                 m_refresh_reg;
    logic                 m_clear_reg;
    logic                 m_last_reg;

    logic [IDX_W-1:0]     idx_new;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENT_W-1:0]     ram_wdata;
    logic [ENT_W-1:0]     ram_rdata;
    logic [ENT_W-1:0]     entry;
    logic [VAL_W:0]       nv_raw;
    logic [VAL_W-1:0]     nv;
    logic [HUE_W+2:0]     hh;
    logic [2:0]           sector;
    logic [T_W-1:0]       t_fac;
    logic [VAL_W+7:0]     full_prod;
    logic [CH_W:0]        full_raw;
    logic [XP_W+7:0]      x_prod;
    logic [9:0]           x_raw;
    logic [CH_W-1:0]      x_ch;
    logic [IDX_W+PIX_W-1:0] pix_ext;

    // next write index: steps forward on a nonzero brightness
    always_comb begin
        idx_new = wr_idx_reg;
        if (s_brightness != '0) begin
            idx_new = (wr_idx_reg == IDX_MAX) ? '0 : wr_idx_reg + 1'b1;
        end
    end

    // entry store write port
    assign ram_we    = cmd.load_write | cmd.wb_en;
    assign ram_waddr = cmd.load_write ? idx_new : cnt_reg;
    assign ram_wdata = cmd.load_write ? {s_hue, s_brightness} : {hue_reg, nv};

    htlb_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_LEDS)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_issue),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    // an entry never written reads as zero
    assign entry = rd_valid_reg ? ram_rdata : '0;

    // decayed value, saturated
    assign nv_raw = prod_reg[2*VAL_W-1:VAL_W-1];
    assign nv     = nv_raw[VAL_W] ? '1 : nv_raw[VAL_W-1:0];

    // hue to sector and rising factor
    assign hh     = {1'b0, hue_reg, 2'b00} + {2'b00, hue_reg, 1'b0};
    assign sector = hh[HUE_W+2:HUE_W];
    assign t_fac  = sector[0] ? (T_W'(1) << HUE_W) - {1'b0, hh[HUE_W-1:0]}
                              : {1'b0, hh[HUE_W-1:0]};

    // primary channel: value * 255 / 2^15
    assign full_prod = {val_reg, 8'd0} - {8'd0, val_reg};
    assign full_raw  = full_prod[VAL_W+7:VAL_W-1];

    // secondary channel: (value * t) * 255 / 2^31
    assign x_prod = {xprod_reg, 8'd0} - {8'd0, xprod_reg};
    assign x_raw  = x_prod[XP_W+7:31];
    assign x_ch   = (x_raw > 10'd255) ? '1 : x_raw[CH_W-1:0];

    assign pix_ext = {{PIX_W{1'b0}}, pix_idx_reg};

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg  <= '0;
            cnt_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_write) begin
                wr_idx_reg         <= idx_new;
                valid_reg[idx_new] <= 1'b1;
            end
            if (cmd.load_clear) begin
                wr_idx_reg <= '0;
            end
            if (cmd.load_decay) begin
                cnt_reg <= '0;
            end else if (cmd.cnt_inc) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.wb_en) begin
                valid_reg[cnt_reg] <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_write) begin
            hue_reg     <= s_hue;
            val_reg     <= s_brightness;
            pix_idx_reg <= idx_new;
        end
        if (cmd.load_decay) begin
            fade_reg <= s_fade;
        end
        if (cmd.rd_issue) begin
            rd_valid_reg <= valid_reg[cnt_reg];
        end
        if (cmd.mul_en) begin
            hue_reg  <= entry[ENT_W-1:VAL_W];
            prod_reg <= entry[VAL_W-1:0] * fade_reg;
        end
        if (cmd.wb_en) begin
            val_reg     <= nv;
            pix_idx_reg <= cnt_reg;
        end
        if (cmd.conv_en) begin
            sector_reg <= sector;
            xprod_reg  <= val_reg * t_fac;
            full_reg   <= full_raw[CH_W] ? '1 : full_raw[CH_W-1:0];
        end
        if (cmd.out_load) begin
            m_refresh_reg <= cmd.out_refresh;
            m_clear_reg   <= cmd.out_clear;
            m_last_reg    <= cmd.out_last;
            if (cmd.out_clear) begin
                m_idx_reg   <= '0;
                m_red_reg   <= '0;
                m_green_reg <= '0;
                m_blue_reg  <= '0;
            end else begin
                m_idx_reg <= pix_ext[PIX_W-1:0];
                case (sector_reg)
                    SEC_RED_UP: begin
                        m_red_reg   <= full_reg;
                        m_green_reg <= x_ch;
                        m_blue_reg  <= '0;
                    end
                    SEC_GRN_DOWN: begin
                        m_red_reg   <= x_ch;
                        m_green_reg <= full_reg;
                        m_blue_reg  <= '0;
                    end
                    SEC_GRN_UP: begin
                        m_red_reg   <= '0;
                        m_green_reg <= full_reg;
                        m_blue_reg  <= x_ch;
                    end
                    SEC_BLU_DOWN: begin
                        m_red_reg   <= '0;
                        m_green_reg <= x_ch;
                        m_blue_reg  <= full_reg;
                    end
                    SEC_BLU_UP: begin
                        m_red_reg   <= x_ch;
                        m_green_reg <= '0;
                        m_blue_reg  <= full_reg;
                    end
                    default: begin
                        m_red_reg   <= full_reg;
                        m_green_reg <= '0;
                        m_blue_reg  <= x_ch;
                    end
                endcase
            end
        end
    end

    assign stat.cnt_last = (cnt_reg == IDX_MAX);
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_pixel_index = m_idx_reg;
    assign m_red         = m_red_reg;
    assign m_green       = m_green_reg;
    assign m_blue        = m_blue_reg;
    assign m_refresh     = m_refresh_reg;
    assign m_clear_all   = m_clear_reg;
    assign m_last        = m_last_reg;

endmodule

[rtl/hue_trail_led_buffer_top.sv]
// Hue trail LED buffer: a ring of NUM_LEDS hue/value entries turned into RGB pixels at
// full saturation. A write item (action 0) steps the write index when brightness is
// nonzero, stores the entry and returns one pixel with refresh set. A decay item
// (action 1) scales every stored value by fade and returns NUM_LEDS pixels in index
// order, last set on the final one. A clear item (action 2) rewinds the write index and
// returns one clear_all result; action 3 returns nothing. One item is worked at a time:
// a write goes through the convert and output steps, a clear through the output step only,
// and a decay runs the controller's read, multiply, write-back, convert and output steps
// for each LED through the entry RAM. The store reads as zero after reset through one
// valid bit per entry, so no clearing pass is needed. The result sits in an output
// register, so a new item is taken while the last result still waits for m_ready.
module hue_trail_led_buffer_top #(
    parameter int NUM_LEDS = htlb_pkg::NUM_LEDS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [htlb_pkg::ACT_W-1:0]       s_action,
    input  logic [htlb_pkg::VAL_W-1:0]       s_brightness,
    input  logic [htlb_pkg::HUE_W-1:0]       s_hue,
    input  logic [htlb_pkg::VAL_W-1:0]       s_fade,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [htlb_pkg::PIX_IDX_W-1:0]   m_pixel_index,
    output logic [htlb_pkg::CH_W-1:0]        m_red,
    output logic [htlb_pkg::CH_W-1:0]        m_green,
    output logic [htlb_pkg::CH_W-1:0]        m_blue,
    output logic                             m_refresh,
    output logic                             m_clear_all,
    output logic                             m_last
);

    htlb_pkg::htlb_cmd_t  cmd;
    htlb_pkg::htlb_stat_t stat;

    // sequencer
    htlb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .stat     (stat),
        .cmd      (cmd)
    );

    // entry store, color conversion and output register
    htlb_dp #(
        .NUM_LEDS (NUM_LEDS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_brightness  (s_brightness),
        .s_hue         (s_hue),
        .s_fade        (s_fade),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_index (m_pixel_index),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_refresh     (m_refresh),
        .m_clear_all   (m_clear_all),
        .m_last        (m_last)
    );

`ifndef NO_ASSERTIONS
    // a pending result is never overwritten
    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("output register loaded while a result is pending");

    // a clear result carries a blank pixel and ends its item
    a_clear_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_clear_all) |-> (m_red == '0 && m_green == '0 && m_blue == '0
                                      && m_pixel_index == '0 && !m_refresh && m_last))
        else $error("clear result not blank");

    // a write pixel is the only result of its item
    a_refresh_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_refresh) |-> (m_last && !m_clear_all))
        else $error("refresh pixel not marked last");

    // no new item is taken during the read, multiply, write-back or convert step of any item
    a_sweep_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_issue || cmd.mul_en || cmd.wb_en || cmd.conv_en) |-> !s_ready)
        else $error("input accepted during pixel work");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int STRIP_LEN    = htlb_pkg::NUM_LEDS_DEF;
    localparam int MAX_WAIT     = 11;
    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_ITEMS = 205;
    localparam int TAIL_CYCLES  = 200;

    // action code the block ignores
    localparam logic [htlb_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [htlb_pkg::PIX_IDX_W-1:0] idx;
        logic [htlb_pkg::CH_W-1:0]      red;
        logic [htlb_pkg::CH_W-1:0]      green;
        logic [htlb_pkg::CH_W-1:0]      blue;
        logic                           refresh;
        logic                           clear_all;
        logic                           last;
    } led_pixel_t;

    typedef struct {
        logic [htlb_pkg::ACT_W-1:0] action;
        logic [htlb_pkg::VAL_W-1:0] bright;
        logic [htlb_pkg::HUE_W-1:0] hue;
        logic [htlb_pkg::VAL_W-1:0] fade;
        bit                         typed;
        led_pixel_t                 want;
    } strip_cmd_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [htlb_pkg::ACT_W-1:0]     s_action;
    logic [htlb_pkg::VAL_W-1:0]     s_brightness;
    logic [htlb_pkg::HUE_W-1:0]     s_hue;
    logic [htlb_pkg::VAL_W-1:0]     s_fade;
    logic                           m_valid;
    logic                           m_ready;
    logic [htlb_pkg::PIX_IDX_W-1:0] m_pixel_index;
    logic [htlb_pkg::CH_W-1:0]      m_red;
    logic [htlb_pkg::CH_W-1:0]      m_green;
    logic [htlb_pkg::CH_W-1:0]      m_blue;
    logic                           m_refresh;
    logic                           m_clear_all;
    logic                           m_last;

    // shadow copy of the led ring
    logic [htlb_pkg::HUE_W-1:0] led_hue [STRIP_LEN];
    logic [htlb_pkg::VAL_W-1:0] led_val [STRIP_LEN];
    int                         write_ptr;

    led_pixel_t pending_pixels [$];
    bit         no_idle;
    int         n_errors;
    int         n_checked;
    int         n_writes;
    int         n_decays;
    int         n_clears;
    int         n_ignored;

    // opening items: reset state, hue sectors, value extremes, every action
    strip_cmd_t opening_cmds [18] = '{
        '{htlb_pkg::ACT_DECAY, 16'd0,     16'h0000, 16'd32768, 1'b0, '0},
        '{htlb_pkg::ACT_WRITE, 16'd32768, 16'h0000, 16'd0,     1'b1,
            '{5'd1, 8'd255, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1}},
        '{htlb_pkg::ACT_WRITE, 16'd32768, 16'h2AAB, 16'd0,     1'b0, '0},
        '{htlb_pkg::ACT_WRITE, 16'd32768, 16'h5555, 16'd0,     1'b0, '0},
        '{htlb_pkg::ACT_WRITE, 16'd65535, 16'h8000, 16'd0,     1'b0, '0},
        '{htlb_pkg::ACT_WRITE, 16'd16384, 16'hB000, 16'd0,     1'b0, '0},
        '{htlb_pkg::ACT_WRITE, 16'd1,     16'hFFFF, 16'd0,     1'b0, '0},
        '{htlb_pkg::ACT_WRITE, 16'd0,     16'h1234, 16'd0,     1'b0, '0},
        '{htlb_pkg::ACT_WRITE, 16'd20000, 16'hE000, 16'd0,     1'b0, '0},
        '{htlb_pkg::ACT_DECAY, 16'd0,     16'h0000, 16'd32768, 1'b0, '0},
        '{htlb_pkg::ACT_DECAY, 16'd0,     16'h0000, 16'd65535, 1'b0, '0},
        '{ACT_UNUSED,          16'hFFFF,  16'hFFFF, 16'hFFFF,  1'b0, '0},
        '{htlb_pkg::ACT_DECAY, 16'd0,     16'h0000, 16'd16384, 1'b0, '0},
        '{htlb_pkg::ACT_CLEAR, 16'd0,     16'h0000, 16'd0,     1'b1,
            '{5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1}},
        '{htlb_pkg::ACT_WRITE, 16'd0,     16'h7777, 16'd0,     1'b1,
            '{5'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1}},
        '{htlb_pkg::ACT_WRITE, 16'd32768, 16'h0000, 16'd0,     1'b1,
            '{5'd1, 8'd255, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1}},
        '{htlb_pkg::ACT_DECAY, 16'd0,     16'h0000, 16'd0,     1'b0, '0},
        '{htlb_pkg::ACT_WRITE, 16'd65535, 16'h0000, 16'd0,     1'b1,
            '{5'd2, 8'd255, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1}}
    };

    hue_trail_led_buffer_top #(
        .NUM_LEDS(STRIP_LEN)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_brightness  (s_brightness),
        .s_hue         (s_hue),
        .s_fade        (s_fade),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_index (m_pixel_index),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_refresh     (m_refresh),
        .m_clear_all   (m_clear_all),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // floor(v * fac * 255 / 2^31), clipped to 255
    function automatic logic [htlb_pkg::CH_W-1:0] scale_channel(
        logic [htlb_pkg::VAL_W-1:0] v, logic [16:0] fac);
        logic [63:0] prod;
        prod = (64'(v) * 64'(fac) * 64'd255) >> 31;
        return (prod > 64'd255) ? 8'd255 : prod[htlb_pkg::CH_W-1:0];
    endfunction

    // full-saturation hsv to rgb for one led
    function automatic led_pixel_t hsv_pixel(int idx, logic [htlb_pkg::HUE_W-1:0] h,
                                             logic [htlb_pkg::VAL_W-1:0] v, logic refresh,
                                             logic last);
        logic [18:0]               hh;
        logic [2:0]                sector;
        logic [16:0]               rise;
        logic [htlb_pkg::CH_W-1:0] full;
        logic [htlb_pkg::CH_W-1:0] part;
        led_pixel_t                p;
        hh     = 19'(h) * 19'd6;
        sector = hh[18:16];
        rise   = sector[0] ? 17'd65536 - 17'(hh[15:0]) : 17'(hh[15:0]);
        full   = scale_channel(v, 17'd65536);
        part   = scale_channel(v, rise);
        p         = '0;
        p.idx     = idx[htlb_pkg::PIX_IDX_W-1:0];
        p.refresh = refresh;
        p.last    = last;
        case (sector)
            3'd0: begin p.red = full;  p.green = part; end
            3'd1: begin p.red = part;  p.green = full; end
            3'd2: begin p.green = full; p.blue = part; end
            3'd3: begin p.green = part; p.blue = full; end
            3'd4: begin p.red = part;  p.blue = full;  end
            default: begin p.red = full; p.blue = part; end
        endcase
        return p;
    endfunction

    // update the shadow ring and queue the pixels an item produces
    task automatic predict_strip(strip_cmd_t c, bit push);
        logic [31:0] faded;
        led_pixel_t  p;
        case (c.action)
            htlb_pkg::ACT_WRITE: begin
                if (c.bright != '0)
                    write_ptr = (write_ptr + 1) % STRIP_LEN;
                led_hue[write_ptr] = c.hue;
                led_val[write_ptr] = c.bright;
                if (push)
                    pending_pixels.push_back(hsv_pixel(write_ptr, c.hue, c.bright, 1'b1, 1'b1));
                n_writes++;
            end
            htlb_pkg::ACT_DECAY: begin
                for (int i = 0; i < STRIP_LEN; i++) begin
                    faded = (32'(led_val[i]) * 32'(c.fade)) >> 15;
                    led_val[i] = (faded > 32'hFFFF) ? 16'hFFFF : faded[htlb_pkg::VAL_W-1:0];
                    if (push)
                        pending_pixels.push_back(hsv_pixel(i, led_hue[i], led_val[i], 1'b0,
                                                           i == STRIP_LEN - 1));
                end
                n_decays++;
            end
            htlb_pkg::ACT_CLEAR: begin
                write_ptr   = 0;
                p           = '0;
                p.clear_all = 1'b1;
                p.last      = 1'b1;
                if (push)
                    pending_pixels.push_back(p);
                n_clears++;
            end
            default: n_ignored++;
        endcase
    endtask

    function automatic strip_cmd_t random_cmd();
        strip_cmd_t c;
        int         pick;
        c.typed = 1'b0;
        c.want  = '0;
        pick = $urandom_range(0, 99);
        if (pick < 79)
            c.action = htlb_pkg::ACT_WRITE;
        else if (pick < 94)
            c.action = htlb_pkg::ACT_DECAY;
        else if (pick < 96)
            c.action = htlb_pkg::ACT_CLEAR;
        else
            c.action = ACT_UNUSED;
        case ($urandom_range(0, 9))
            0: c.bright = '0;
            1: c.bright = 16'($urandom);
            2: c.bright = 16'd32768;
            default: c.bright = 16'($urandom_range(1, 32768));
        endcase
        c.hue = 16'($urandom);
        case ($urandom_range(0, 7))
            0: c.fade = 16'($urandom);
            1: c.fade = 16'd32768;
            default: c.fade = 16'($urandom_range(20000, 32768));
        endcase
        return c;
    endfunction

    // present one item, wait for it to be taken, then predict
    task automatic drive_cmd(strip_cmd_t c);
        int gap;
        gap = idle_cycles();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= c.action;
        s_brightness <= c.bright;
        s_hue        <= c.hue;
        s_fade       <= c.fade;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        predict_strip(c, !c.typed);
        if (c.typed)
            pending_pixels.push_back(c.want);
    endtask

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // result side: random stalls on m_ready
    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = idle_cycles();
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (!m_valid);
            @(posedge aclk);
        end
    end

    // compare every accepted pixel with the oldest prediction
    initial begin
        led_pixel_t want;
        forever begin
            @(negedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected pixel idx %0d rgb %0d/%0d/%0d", $time,
                             m_pixel_index, m_red, m_green, m_blue);
                end else begin
                    want = pending_pixels.pop_front();
                    n_checked++;
                    report_field("pixel_index", 32'(want.idx), 32'(m_pixel_index));
                    report_field("red", 32'(want.red), 32'(m_red));
                    report_field("green", 32'(want.green), 32'(m_green));
                    report_field("blue", 32'(want.blue), 32'(m_blue));
                    report_field("refresh", 32'(want.refresh), 32'(m_refresh));
                    report_field("clear_all", 32'(want.clear_all), 32'(m_clear_all));
                    report_field("last", 32'(want.last), 32'(m_last));
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    initial begin
        int quiet;
        quiet = 0;
        wait (aresetn);
        while (quiet < IDLE_LIMIT) begin
            @(negedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("hue_trail_led_buffer_top regression: fail");
        $finish;
    end

    // reset, opening items, random items, drain
    initial begin
        strip_cmd_t c;
        int         n_rand;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_action     <= htlb_pkg::ACT_WRITE;
        s_brightness <= '0;
        s_hue        <= '0;
        s_fade       <= '0;
        no_idle   = 1'b0;
        n_errors  = 0;
        n_checked = 0;
        n_writes  = 0;
        n_decays  = 0;
        n_clears  = 0;
        n_ignored = 0;
        write_ptr = 0;
        for (int i = 0; i < STRIP_LEN; i++) begin
            led_hue[i] = '0;
            led_val[i] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening_cmds[k])
            drive_cmd(opening_cmds[k]);

        // random part, in chunks that sometimes run without idling
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS) begin
            if (n_rand % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            c = random_cmd();
            drive_cmd(c);
            if (c.action != ACT_UNUSED)
                n_rand++;
        end
        s_valid <= 1'b0;

        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("items: %0d writes, %0d decays, %0d clears, %0d ignored",
                 n_writes, n_decays, n_clears, n_ignored);
        $display("pixels checked: %0d, mismatches: %0d", n_checked, n_errors);
        if (n_errors == 0 && pending_pixels.size() == 0)
            $display("hue_trail_led_buffer_top regression: pass");
        else
            $display("hue_trail_led_buffer_top regression: fail");
        $finish;
    end

endmodule
